// File: design/htsw_pkg.sv
// ---------------------------------------------------------------------------
// htsw_pkg
// Shared constants for the HTML text stripper: character codes, the tag
// names that have an effect and the href attribute pattern.
// ---------------------------------------------------------------------------
package htsw_pkg;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;

  // Tag names, lowercase, padded with zeros to the longest name.
  localparam int NUM_TAGS     = 15;
  localparam int TAG_PAT_LEN  = 7;

  localparam int TAG_SCRIPT     = 0;
  localparam int TAG_END_SCRIPT = 1;
  localparam int TAG_STYLE      = 2;
  localparam int TAG_END_STYLE  = 3;
  localparam int TAG_BREAK_LO   = 4;
  localparam int TAG_BREAK_HI   = 13;
  localparam int TAG_ANCHOR     = 14;

  localparam int TAG_LEN [NUM_TAGS] = '{6, 7, 5, 6, 2, 1, 2, 3, 4, 2, 2, 2, 2, 2, 1};

  localparam logic [7:0] TAG_CHR [NUM_TAGS][TAG_PAT_LEN] = '{
    '{"s", "c", "r", "i", "p", "t", 8'h00},
    '{"/", "s", "c", "r", "i", "p", "t"},
    '{"s", "t", "y", "l", "e", 8'h00, 8'h00},
    '{"/", "s", "t", "y", "l", "e", 8'h00},
    '{"b", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"p", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"/", "p", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"d", "i", "v", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"/", "d", "i", "v", 8'h00, 8'h00, 8'h00},
    '{"l", "i", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"h", "1", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"h", "2", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"h", "3", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"h", "4", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"a", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  // Attribute pattern that starts a link capture.
  localparam int HREF_LEN = 6;
  localparam logic [7:0] HREF_PAT [HREF_LEN] = '{"h", "r", "e", "f", "=", 8'h22};

  // Output sequencer states.
  typedef enum logic [2:0] {
    ES_IDLE = 3'b001,
    ES_READ = 3'b010,
    ES_LOAD = 3'b100
  } emit_state_e;

endpackage

// File: design/htsw_ram.sv
// ---------------------------------------------------------------------------
// htsw_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module htsw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/htsw_parse.sv
// ---------------------------------------------------------------------------
// htsw_parse
// Byte parser: tracks tags, captures href values into the link RAM, folds
// whitespace into the line ring RAM and requests emission of lines and links.
// ---------------------------------------------------------------------------
module htsw_parse
  import htsw_pkg::*;
#(
  parameter int LINE_MAX     = 64,
  parameter int LINK_MAX     = 64,
  parameter int TAG_NAME_MAX = 8,
  localparam int LA = $clog2(LINE_MAX),
  localparam int KA = $clog2(LINK_MAX),
  localparam int LW = $clog2(LINE_MAX + 1),
  localparam int KW = $clog2(LINK_MAX + 1),
  localparam int CW = (LW > KW) ? LW : KW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          in_cmd_i,
  input  logic [7:0]    in_byte_i,
  input  logic [6:0]    wrap_width_i,
  input  logic          emit_busy_i,
  output logic          go_o,
  output logic          kind_o,
  output logic [LA-1:0] start_o,
  output logic [CW-1:0] count_o,
  output logic          line_we_o,
  output logic [LA-1:0] line_waddr_o,
  output logic [7:0]    line_wdata_o,
  output logic          link_we_o,
  output logic [KA-1:0] link_waddr_o,
  output logic [7:0]    link_wdata_o
);

  localparam int TA = $clog2(TAG_NAME_MAX);
  localparam int TW = $clog2(TAG_NAME_MAX + 1);
  localparam int SW = LA + 2;

  logic acc;

  logic in_tag_q, in_tag_d, script_q, script_d, style_q, style_d;
  logic [7:0] tag_chr_q [TAG_NAME_MAX];
  logic [TW-1:0] tag_len_q, tag_len_d;
  logic closed_q, closed_d, ovf_q, ovf_d;
  logic tag_we;
  logic [7:0] tag_lc;
  logic [2:0] prog_q, prog_d, prog_n;
  logic cap_q, cap_d, done_q, done_d;
  logic [KW-1:0] link_len_q, link_len_d;

  logic [LA-1:0] head_q, head_d;
  logic [LW-1:0] len_q, len_d, len1, wrap_w, pos_q, pos_d, pos_n;
  logic sv_q, sv_d, sv_n, prev_q, prev_d;

  logic go_q, go_d, kind_q, kind_d;
  logic [LA-1:0] start_q, start_d;
  logic [CW-1:0] count_q, count_d;

  logic [7:0] tc;
  logic is_sp;
  logic [SW-1:0] wsum, hsum;
  logic [NUM_TAGS-1:0] match;

  assign acc        = in_valid_i & in_ready_o;
  assign in_ready_o = ~emit_busy_i & ~go_q;
  assign go_o       = go_q;
  assign kind_o     = kind_q;
  assign start_o    = start_q;
  assign count_o    = count_q;

  // Effective wrap width, clamped to 1..LINE_MAX.
  always_comb begin
    if (wrap_width_i == 7'd0) begin
      wrap_w = LW'(1);
    end else if (wrap_width_i > 7'(LINE_MAX)) begin
      wrap_w = LW'(LINE_MAX);
    end else begin
      wrap_w = LW'(wrap_width_i);
    end
  end

  // Tag name comparison against every tag that has an effect.
  always_comb begin
    for (int p = 0; p < NUM_TAGS; p++) begin
      match[p] = ~ovf_q && (tag_len_q == TW'(TAG_LEN[p]));
      for (int i = 0; i < TAG_PAT_LEN; i++) begin
        if (i < TAG_LEN[p] && tag_chr_q[i] != TAG_CHR[p][i]) begin
          match[p] = 1'b0;
        end
      end
    end
  end

  // Text character after whitespace folding, and ring write address.
  assign tc    = (in_byte_i == CH_LF || in_byte_i == CH_CR || in_byte_i == CH_TAB) ?
                 CH_SPACE : in_byte_i;
  assign is_sp = (tc == CH_SPACE);
  assign wsum  = SW'(head_q) + SW'(len_q);
  assign line_waddr_o = (wsum >= SW'(LINE_MAX)) ? LA'(wsum - SW'(LINE_MAX)) : LA'(wsum);
  assign line_wdata_o = tc;
  assign link_waddr_o = link_len_q[KA-1:0];
  assign link_wdata_o = in_byte_i;
  assign tag_lc = (in_byte_i >= CH_UP_A && in_byte_i <= CH_UP_Z) ?
                  in_byte_i + 8'd32 : in_byte_i;

  assign len1  = len_q + LW'(1);
  assign pos_n = is_sp ? len_q : pos_q;
  assign sv_n  = sv_q | is_sp;
  assign hsum  = SW'(head_q) + SW'(pos_n) + SW'(1);

  // Next-state logic for one accepted item.
  always_comb begin
    in_tag_d = in_tag_q;   script_d = script_q;  style_d = style_q;
    tag_len_d = tag_len_q; closed_d = closed_q;  ovf_d = ovf_q;
    prog_d = prog_q;       cap_d = cap_q;        done_d = done_q;
    link_len_d = link_len_q;
    head_d = head_q; len_d = len_q; pos_d = pos_q; sv_d = sv_q; prev_d = prev_q;
    go_d = 1'b0; kind_d = kind_q; start_d = start_q; count_d = count_q;
    tag_we = 1'b0; line_we_o = 1'b0; link_we_o = 1'b0;
    prog_n = 3'd0;

    if (acc) begin
      if (in_cmd_i) begin
        // End of document: flush the line, then start over.
        if (len_q != '0) begin
          go_d = 1'b1; kind_d = 1'b0; start_d = head_q; count_d = CW'(len_q);
        end
        in_tag_d = 1'b0; script_d = 1'b0; style_d = 1'b0;
        tag_len_d = '0; closed_d = 1'b0; ovf_d = 1'b0;
        prog_d = 3'd0; cap_d = 1'b0; done_d = 1'b0; link_len_d = '0;
        head_d = '0; len_d = '0; pos_d = '0; sv_d = 1'b0; prev_d = 1'b0;
      end else if (in_byte_i == CH_LT) begin
        // A new tag drops the old name and href.
        in_tag_d = 1'b1;
        tag_len_d = '0; closed_d = 1'b0; ovf_d = 1'b0;
        prog_d = 3'd0; cap_d = 1'b0; done_d = 1'b0; link_len_d = '0;
      end else if (in_byte_i == CH_GT) begin
        // Close (or close again) the last tag.
        in_tag_d = 1'b0;
        if (match[TAG_SCRIPT]) begin
          script_d = 1'b1;
        end else if (match[TAG_END_SCRIPT]) begin
          script_d = 1'b0;
        end else if (match[TAG_STYLE]) begin
          style_d = 1'b1;
        end else if (match[TAG_END_STYLE]) begin
          style_d = 1'b0;
        end else if (|match[TAG_BREAK_HI:TAG_BREAK_LO]) begin
          if (len_q != '0) begin
            go_d = 1'b1; kind_d = 1'b0; start_d = head_q; count_d = CW'(len_q);
          end
          len_d = '0; sv_d = 1'b0;
        end else if (match[TAG_ANCHOR] && done_q) begin
          go_d = 1'b1; kind_d = 1'b1; start_d = '0; count_d = CW'(link_len_q);
        end
      end else if (in_tag_q) begin
        // Tag name up to the first space.
        if (!closed_q) begin
          if (in_byte_i == CH_SPACE) begin
            closed_d = 1'b1;
          end else if (tag_len_q < TW'(TAG_NAME_MAX)) begin
            tag_we = 1'b1;
            tag_len_d = tag_len_q + TW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        // href matcher and capture.
        if (!done_q) begin
          if (cap_q) begin
            if (in_byte_i == CH_QUOTE) begin
              cap_d = 1'b0; done_d = 1'b1;
            end else if (link_len_q < KW'(LINK_MAX)) begin
              link_we_o = 1'b1;
              link_len_d = link_len_q + KW'(1);
            end
          end else begin
            if (prog_q < 3'(HREF_LEN) && in_byte_i == HREF_PAT[prog_q]) begin
              prog_n = prog_q + 3'd1;
            end else begin
              prog_n = (in_byte_i == CH_H) ? 3'd1 : 3'd0;
            end
            if (prog_n >= 3'(HREF_LEN)) begin
              prog_d = 3'd0; cap_d = 1'b1; link_len_d = '0;
            end else begin
              prog_d = prog_n;
            end
          end
        end
      end else if (!(script_q || style_q)) begin
        // Visible text: fold spaces, append, wrap.
        if (!(is_sp && (len_q == '0 || prev_q))) begin
          line_we_o = 1'b1;
          prev_d = is_sp;
          if (len1 < wrap_w) begin
            len_d = len1; sv_d = sv_n; pos_d = pos_n;
          end else if (sv_n && pos_n != '0) begin
            go_d = 1'b1; kind_d = 1'b0; start_d = head_q; count_d = CW'(pos_n);
            head_d = (hsum >= SW'(LINE_MAX)) ? LA'(hsum - SW'(LINE_MAX)) : LA'(hsum);
            len_d = len1 - pos_n - LW'(1);
            sv_d = 1'b0;
          end else begin
            go_d = 1'b1; kind_d = 1'b0; start_d = head_q; count_d = CW'(len1);
            len_d = '0; sv_d = 1'b0;
          end
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_tag_q <= 1'b0; script_q <= 1'b0; style_q <= 1'b0;
      tag_len_q <= '0; closed_q <= 1'b0; ovf_q <= 1'b0;
      prog_q <= 3'd0; cap_q <= 1'b0; done_q <= 1'b0; link_len_q <= '0;
      head_q <= '0; len_q <= '0; pos_q <= '0; sv_q <= 1'b0; prev_q <= 1'b0;
      go_q <= 1'b0; kind_q <= 1'b0; start_q <= '0; count_q <= '0;
    end else begin
      in_tag_q <= in_tag_d; script_q <= script_d; style_q <= style_d;
      tag_len_q <= tag_len_d; closed_q <= closed_d; ovf_q <= ovf_d;
      prog_q <= prog_d; cap_q <= cap_d; done_q <= done_d; link_len_q <= link_len_d;
      head_q <= head_d; len_q <= len_d; pos_q <= pos_d; sv_q <= sv_d; prev_q <= prev_d;
      go_q <= go_d; kind_q <= kind_d; start_q <= start_d; count_q <= count_d;
    end
  end

  // Tag name characters; only entries below the length are compared.
  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_chr_q[tag_len_q[TA-1:0]] <= tag_lc;
    end
  end

endmodule

// File: design/htsw_emit.sv
// ---------------------------------------------------------------------------
// htsw_emit
// Output sequencer: reads a line or link out of its RAM one character at a
// time into the output register.
// ---------------------------------------------------------------------------
module htsw_emit
  import htsw_pkg::*;
#(
  parameter int LINE_MAX = 64,
  parameter int LINK_MAX = 64,
  localparam int LA = $clog2(LINE_MAX),
  localparam int KA = $clog2(LINK_MAX),
  localparam int LW = $clog2(LINE_MAX + 1),
  localparam int KW = $clog2(LINK_MAX + 1),
  localparam int CW = (LW > KW) ? LW : KW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          go_i,
  input  logic          kind_i,
  input  logic [LA-1:0] start_i,
  input  logic [CW-1:0] count_i,
  output logic          busy_o,
  output logic          line_re_o,
  output logic [LA-1:0] line_raddr_o,
  input  logic [7:0]    line_rdata_i,
  output logic          link_re_o,
  output logic [KA-1:0] link_raddr_o,
  input  logic [7:0]    link_rdata_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          out_kind_o,
  output logic [7:0]    out_byte_o,
  output logic          out_has_o,
  output logic          out_last_o
);

  emit_state_e state_q, state_d;
  logic kind_q, kind_d, empty_q, empty_d;
  logic [LA-1:0] line_ptr_q, line_ptr_d;
  logic [KA-1:0] link_ptr_q, link_ptr_d;
  logic [CW-1:0] rem_q, rem_d;
  logic ov_q, ov_d, ok_q, ok_d, oh_q, oh_d, ol_q, ol_d;
  logic [7:0] ob_q, ob_d;
  logic free;

  assign busy_o       = (state_q != ES_IDLE);
  assign free         = ~ov_q | out_ready_i;
  assign line_raddr_o = line_ptr_q;
  assign link_raddr_o = link_ptr_q;
  assign out_valid_o  = ov_q;
  assign out_kind_o   = ok_q;
  assign out_byte_o   = ob_q;
  assign out_has_o    = oh_q;
  assign out_last_o   = ol_q;

  // Sequencer: read one character, then move it into the output register.
  always_comb begin
    state_d = state_q; kind_d = kind_q; empty_d = empty_q;
    line_ptr_d = line_ptr_q; link_ptr_d = link_ptr_q; rem_d = rem_q;
    ov_d = ov_q & ~out_ready_i;
    ok_d = ok_q; ob_d = ob_q; oh_d = oh_q; ol_d = ol_q;
    line_re_o = 1'b0; link_re_o = 1'b0;
    unique case (state_q)
      ES_IDLE: begin
        if (go_i) begin
          kind_d = kind_i; line_ptr_d = start_i; link_ptr_d = '0;
          rem_d = count_i; empty_d = (count_i == '0);
          state_d = (count_i == '0) ? ES_LOAD : ES_READ;
        end
      end
      ES_READ: begin
        line_re_o = ~kind_q;
        link_re_o = kind_q;
        state_d = ES_LOAD;
      end
      ES_LOAD: begin
        if (free) begin
          ov_d = 1'b1; ok_d = kind_q;
          if (empty_q) begin
            ob_d = 8'h00; oh_d = 1'b0; ol_d = 1'b1;
            state_d = ES_IDLE;
          end else begin
            ob_d = kind_q ? link_rdata_i : line_rdata_i;
            oh_d = 1'b1;
            ol_d = (rem_q == CW'(1));
            line_ptr_d = (line_ptr_q == LA'(LINE_MAX - 1)) ? '0 : line_ptr_q + LA'(1);
            link_ptr_d = link_ptr_q + KA'(1);
            rem_d = rem_q - CW'(1);
            state_d = (rem_q == CW'(1)) ? ES_IDLE : ES_READ;
          end
        end
      end
      default: state_d = ES_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ES_IDLE; kind_q <= 1'b0; empty_q <= 1'b0;
      line_ptr_q <= '0; link_ptr_q <= '0; rem_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; kind_q <= kind_d; empty_q <= empty_d;
      line_ptr_q <= line_ptr_d; link_ptr_q <= link_ptr_d; rem_q <= rem_d; ov_q <= ov_d;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    ok_q <= ok_d; ob_q <= ob_d; oh_q <= oh_d; ol_q <= ol_d;
  end

endmodule

// File: design/html_text_strip_wrap_links.sv
// ---------------------------------------------------------------------------
// html_text_strip_wrap_links
// HTML to plain text: strips tags, folds whitespace, wraps lines and pulls
// out link targets, one character per output transfer.
// ---------------------------------------------------------------------------
// A byte that triggers an emission sets the parser's go register; the sequencer
//   then reads each character from RAM and loads it into the output register (an
//   empty link skips the read). Input is taken at one byte per cycle while no
//   emission is pending or running; each output character takes a RAM read and an
//   output register load, and an emission stretches while the output stalls.
// Reset: asynchronous, active low; clears the parser control state, wrap width = 64.
// ---------------------------------------------------------------------------
module html_text_strip_wrap_links #(
  parameter int LINE_MAX     = 64,
  parameter int LINK_MAX     = 64,
  parameter int TAG_NAME_MAX = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: wrap width.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic        s_axis_tuser,   // [0] command
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] has_byte, rest zero
  output logic        m_axis_tuser,   // [0] kind
  output logic        m_axis_tlast    // last
);

  localparam int LA = $clog2(LINE_MAX);
  localparam int KA = $clog2(LINK_MAX);
  localparam int LW = $clog2(LINE_MAX + 1);
  localparam int KW = $clog2(LINK_MAX + 1);
  localparam int CW = (LW > KW) ? LW : KW;

  logic [6:0] wrap_q;
  logic go, kind, busy;
  logic [LA-1:0] start;
  logic [CW-1:0] count;
  logic line_we, line_re, link_we, link_re;
  logic [LA-1:0] line_waddr, line_raddr;
  logic [KA-1:0] link_waddr, link_raddr;
  logic [7:0] line_wdata, line_rdata, link_wdata, link_rdata, obyte;
  logic ohas;

  // Wrap width register.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q <= 7'd64;
    end else if (cfg_valid_i) begin
      wrap_q <= cfg_data_i;
    end
  end

  htsw_parse #(
    .LINE_MAX(LINE_MAX), .LINK_MAX(LINK_MAX), .TAG_NAME_MAX(TAG_NAME_MAX)
  ) u_parse (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_cmd_i(s_axis_tuser), .in_byte_i(s_axis_tdata),
    .wrap_width_i(wrap_q), .emit_busy_i(busy),
    .go_o(go), .kind_o(kind), .start_o(start), .count_o(count),
    .line_we_o(line_we), .line_waddr_o(line_waddr), .line_wdata_o(line_wdata),
    .link_we_o(link_we), .link_waddr_o(link_waddr), .link_wdata_o(link_wdata)
  );

  htsw_ram #(.WIDTH(8), .DEPTH(LINE_MAX)) u_line_ram (
    .clk_i, .we_i(line_we), .waddr_i(line_waddr), .wdata_i(line_wdata),
    .re_i(line_re), .raddr_i(line_raddr), .rdata_o(line_rdata)
  );

  htsw_ram #(.WIDTH(8), .DEPTH(LINK_MAX)) u_link_ram (
    .clk_i, .we_i(link_we), .waddr_i(link_waddr), .wdata_i(link_wdata),
    .re_i(link_re), .raddr_i(link_raddr), .rdata_o(link_rdata)
  );

  htsw_emit #(.LINE_MAX(LINE_MAX), .LINK_MAX(LINK_MAX)) u_emit (
    .clk_i, .rst_ni,
    .go_i(go), .kind_i(kind), .start_i(start), .count_i(count), .busy_o(busy),
    .line_re_o(line_re), .line_raddr_o(line_raddr), .line_rdata_i(line_rdata),
    .link_re_o(link_re), .link_raddr_o(link_raddr), .link_rdata_i(link_rdata),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_kind_o(m_axis_tuser), .out_byte_o(obyte), .out_has_o(ohas),
    .out_last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, ohas, obyte};

endmodule
